/* design/dt3s_pkg.sv */
// Shared types and constants for the dequantized top-three selector.
// Request and result payload structs, label kinds and register indexes.
// No dependencies.
`default_nettype none

package dt3s_pkg;

   // Width of a dequantized score: signed Q10.24
   localparam int SCORE_W = 35;

   // Reset value of a ranking slot: -1.0 in Q.24
   localparam logic signed [SCORE_W-1:0] MINUS_ONE_Q24 = -35'sd16777216;

   // Class count at which index 0 is the background class
   localparam int BG_CLASS_COUNT = 1001;

   // Label kinds
   localparam logic [1:0] KIND_EMPTY      = 2'd0;
   localparam logic [1:0] KIND_LABEL      = 2'd1;
   localparam logic [1:0] KIND_BACKGROUND = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN    = 2'd3;

   // Rank of the final result of a vector
   localparam logic [1:0] RANK_LAST = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SIGNED_MODE = 2'd0;
   localparam logic [1:0] CSR_ZERO_POINT  = 2'd1;
   localparam logic [1:0] CSR_SCALE_Q24   = 2'd2;
   localparam logic [1:0] CSR_LABEL_COUNT = 2'd3;

   // One class score request
   typedef struct packed {
      logic [7:0] raw_score;
      logic       is_last;
   } req_payload_type;

   // One ranked result
   typedef struct packed {
      logic [1:0]  rank;
      logic [10:0] label_index;
      logic [1:0]  label_kind;
      logic [32:0] score;
      logic        last_result;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* design/dequantized_top3_selector_top.sv */
// Dequantized top-three selector: input register, multiplier stage, ranking
// registers, a three-entry result buffer and an output register. Depends on dt3s_pkg.
`default_nettype none

// The block takes one quantized class score per cycle while req_stall is low
// and dequantizes it as (q - zp_offset) * scale_q24 into signed Q10.24. It
// keeps a running top three (ties keep the earlier index) and, on the request
// marked is_last, hands out three ranked results on rsp and starts a new vector.
// A request flows through two register stages (input register, then the
// 10x25 multiplier register) before it enters the ranking registers; the
// results of a vector then pass through the result buffer and the output
// register, the second and third following the first on the next cycles unless rsp stalls.
// Requests are taken every cycle; the one limit is the result buffer, which
// holds one vector's three results and hands out one per cycle: a last
// request that reaches the ranking stage before the previous vector's third
// result leaves holds the pipeline (req_stall high) until that result is
// taken, so vectors shorter than three requests, or a stalled rsp side, slow
// the input. Configuration writes are always taken (csr_ready is high) and
// must be made while the block is idle.
module dequantized_top3_selector_top
   import dt3s_pkg::*;
#(
   parameter int MAX_CLASSES = 2048
) (
   input  wire logic            clock,
   input  wire logic            reset,
   // class score requests
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   // ranked results
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload,
   // configuration writes
   input  wire logic            csr_valid,
   output      logic            csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [23:0]     csr_data
);

   localparam int CNT_W = $clog2(MAX_CLASSES + 1);
   localparam int IDX_W = $clog2(MAX_CLASSES);

   // configuration registers
   logic        signed_mode_ff;
   logic [8:0]  zp_offset_ff;
   logic [23:0] scale_q24_ff;
   logic [11:0] label_count_ff;

   // input register
   logic            in_valid_ff;
   req_payload_type in_ff;

   // multiplier stage
   logic                      score_valid_ff;
   logic                      score_last_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic signed [9:0]         q_val;
   logic signed [9:0]         zp_val;
   logic signed [9:0]         diff;
   logic signed [SCORE_W-1:0] product;

   // ranking state
   logic signed [SCORE_W-1:0] best_score_ff [3];
   logic [IDX_W-1:0]          best_idx_ff   [3];
   logic [2:0]                slot_valid_ff;
   logic [CNT_W-1:0]          item_count_ff;
   logic signed [SCORE_W-1:0] best_score_in [3];
   logic [IDX_W-1:0]          best_idx_in   [3];
   logic [2:0]                slot_valid_in;
   logic [CNT_W-1:0]          item_count_in;
   logic                      take;
   logic                      gt0;
   logic                      gt1;
   logic                      gt2;
   logic [IDX_W-1:0]          new_idx;

   // result buffer
   logic signed [SCORE_W-1:0] snap_score_ff [3];
   logic [IDX_W-1:0]          snap_idx_ff   [3];
   logic [2:0]                snap_valid_ff;
   logic [CNT_W-1:0]          snap_count_ff;
   logic                      buf_busy_ff;
   logic [1:0]                ptr_ff;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            load_out;

   // pipeline control
   logic buf_free;
   logic hold;
   logic adv;
   logic emit;

   // classification of the selected buffer entry
   logic signed [SCORE_W-1:0] sel_score;
   logic [IDX_W-1:0]          sel_idx;
   logic                      sel_valid;
   logic                      is_bg_vector;
   logic [31:0]               shifted_idx;

   // the buffer can take a new vector once its third result leaves
   assign buf_free  = !buf_busy_ff || (load_out && (ptr_ff == RANK_LAST));

   // hold the input, multiplier and ranking stages while a last request waits for the result buffer
   assign hold      = score_valid_ff && score_last_ff && !buf_free;
   assign adv       = !hold;
   assign req_stall = hold;
   assign emit      = adv && score_valid_ff && score_last_ff;
   assign csr_ready = 1'b1;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
         zp_offset_ff   <= 9'd0;
         scale_q24_ff   <= 24'd65536;
         label_count_ff <= 12'd1000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIGNED_MODE: signed_mode_ff <= csr_data[0];
            CSR_ZERO_POINT:  zp_offset_ff   <= csr_data[8:0];
            CSR_SCALE_Q24:   scale_q24_ff   <= csr_data[23:0];
            CSR_LABEL_COUNT: label_count_ff <= csr_data[11:0];
            default: begin
            end
         endcase
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_payload;
      end
   end

   // dequantize: (q - zp) * scale, exact in 35 bits
   always_comb begin
      if (signed_mode_ff) begin
         q_val = {{2{in_ff.raw_score[7]}}, in_ff.raw_score};
      end else begin
         q_val = {2'b00, in_ff.raw_score};
      end
      zp_val  = {zp_offset_ff[8], zp_offset_ff};
      diff    = q_val - zp_val;
      product = $signed({{(SCORE_W-10){diff[9]}}, diff})
              * $signed({{(SCORE_W-24){1'b0}}, scale_q24_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_valid_ff <= 1'b0;
      end else if (adv) begin
         score_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         score_ff      <= product;
         score_last_ff <= in_ff.is_last;
      end
   end

   // insert the new score into the running top three
   always_comb begin
      take    = score_valid_ff && (item_count_ff < CNT_W'(MAX_CLASSES));
      gt0     = score_ff > best_score_ff[0];
      gt1     = score_ff > best_score_ff[1];
      gt2     = score_ff > best_score_ff[2];
      new_idx = item_count_ff[IDX_W-1:0];

      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      slot_valid_in = slot_valid_ff;
      item_count_in = item_count_ff;

      if (take) begin
         item_count_in = item_count_ff + CNT_W'(1);
         if (gt0) begin
            best_score_in[2] = best_score_ff[1];
            best_idx_in[2]   = best_idx_ff[1];
            slot_valid_in[2] = slot_valid_ff[1];
            best_score_in[1] = best_score_ff[0];
            best_idx_in[1]   = best_idx_ff[0];
            slot_valid_in[1] = slot_valid_ff[0];
            best_score_in[0] = score_ff;
            best_idx_in[0]   = new_idx;
            slot_valid_in[0] = 1'b1;
         end else if (gt1) begin
            best_score_in[2] = best_score_ff[1];
            best_idx_in[2]   = best_idx_ff[1];
            slot_valid_in[2] = slot_valid_ff[1];
            best_score_in[1] = score_ff;
            best_idx_in[1]   = new_idx;
            slot_valid_in[1] = 1'b1;
         end else if (gt2) begin
            best_score_in[2] = score_ff;
            best_idx_in[2]   = new_idx;
            slot_valid_in[2] = 1'b1;
         end
      end
   end

   // advance ranking state; clear it after a last request
   always_ff @(posedge clock) begin
      if (reset || emit) begin
         for (int i = 0; i < 3; i++) begin
            best_score_ff[i] <= MINUS_ONE_Q24;
            best_idx_ff[i]   <= '0;
         end
         slot_valid_ff <= 3'b000;
         item_count_ff <= '0;
      end else if (adv) begin
         best_score_ff <= best_score_in;
         best_idx_ff   <= best_idx_in;
         slot_valid_ff <= slot_valid_in;
         item_count_ff <= item_count_in;
      end
   end

   // snapshot the final ranking into the result buffer
   always_ff @(posedge clock) begin
      if (emit) begin
         snap_score_ff <= best_score_in;
         snap_idx_ff   <= best_idx_in;
         snap_valid_ff <= slot_valid_in;
         snap_count_ff <= item_count_in;
      end
   end

   assign load_out = buf_busy_ff && (!rsp_valid_ff || !rsp_stall);

   // drain the buffer one result per cycle unless rsp stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_busy_ff <= 1'b0;
         ptr_ff      <= 2'd0;
      end else if (emit) begin
         buf_busy_ff <= 1'b1;
         ptr_ff      <= 2'd0;
      end else if (load_out) begin
         if (ptr_ff == RANK_LAST) begin
            buf_busy_ff <= 1'b0;
            ptr_ff      <= 2'd0;
         end else begin
            ptr_ff <= ptr_ff + 2'd1;
         end
      end
   end

   // classify the selected slot
   always_comb begin
      case (ptr_ff)
         2'd0: begin
            sel_score = snap_score_ff[0];
            sel_idx   = snap_idx_ff[0];
            sel_valid = snap_valid_ff[0];
         end
         2'd1: begin
            sel_score = snap_score_ff[1];
            sel_idx   = snap_idx_ff[1];
            sel_valid = snap_valid_ff[1];
         end
         default: begin
            sel_score = snap_score_ff[2];
            sel_idx   = snap_idx_ff[2];
            sel_valid = snap_valid_ff[2];
         end
      endcase

      is_bg_vector = (32'(snap_count_ff) == 32'(BG_CLASS_COUNT));
      if (is_bg_vector) begin
         shifted_idx = 32'(sel_idx) - 32'd1;
      end else begin
         shifted_idx = 32'(sel_idx);
      end

      rsp_in             = '0;
      rsp_in.rank        = ptr_ff;
      rsp_in.last_result = (ptr_ff == RANK_LAST);
      rsp_in.label_kind  = KIND_EMPTY;
      if (sel_valid) begin
         if (is_bg_vector && (sel_idx == '0)) begin
            rsp_in.label_kind = KIND_BACKGROUND;
         end else if (shifted_idx >= 32'(label_count_ff)) begin
            rsp_in.label_kind = KIND_UNKNOWN;
         end else begin
            rsp_in.label_kind  = KIND_LABEL;
            rsp_in.label_index = shifted_idx[10:0];
         end
      end
      // clamp negative scores to zero
      if (sel_score[SCORE_W-1]) begin
         rsp_in.score = '0;
      end else begin
         rsp_in.score = sel_score[32:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a last request never overwrites a buffer that is still draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!buf_busy_ff || (load_out && (ptr_ff == RANK_LAST))))
      else $error("last request advanced while result buffer busy");

   // ranking state is back at reset values after a vector ends
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (item_count_ff == '0) && (slot_valid_ff == 3'b000))
      else $error("ranking state not cleared after last request");

   // the final result of a vector carries rank two
   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_result == (rsp_payload.rank == RANK_LAST)))
      else $error("last_result does not match rank");

   // buffer index stays within three entries
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      buf_busy_ff |-> (ptr_ff != 2'd3))
      else $error("result buffer index out of range");

endmodule

`default_nettype wire

/* bench/dt3s_rank_checker.sv */
// Checker for the dequantized top-three selector: watches the req, rsp and csr
// channels, predicts the ranked results of each score vector and compares them.
// Depends on dt3s_pkg.
module dt3s_rank_checker
   import dt3s_pkg::*;
#(
   parameter int MAX_CLASSES = 2048
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [23:0]     csr_data,
   output int              fail_count,
   output int              pending_results,
   output int              vectors_seen,
   output int              results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the registers
   logic                      mode_signed;
   logic [8:0]                zero_pt;
   logic [23:0]               scale;
   logic [11:0]               num_labels;

   // Running top three of the current vector
   logic signed [SCORE_W-1:0] top_score [3];
   logic [11:0]               top_index [3];
   logic                      top_used  [3];
   logic [11:0]               class_count;

   // Ranked results still owed by the block, oldest first
   rsp_payload_type           pending_ranks [$];
   rsp_payload_type           want;

   task automatic clear_ranking;
      int k;
      for (k = 0; k < 3; k++) begin
         top_score[k] = MINUS_ONE_Q24;
         top_index[k] = '0;
         top_used[k]  = 1'b0;
      end
      class_count = '0;
   endtask

   // (q - zero_point) * scale as signed Q10.24
   function automatic logic signed [SCORE_W-1:0] dequantize(input logic [7:0] raw);
      int     q;
      int     zp;
      longint product;
      q  = mode_signed ? int'(signed'(raw)) : int'(raw);
      zp = int'(signed'(zero_pt));
      product = longint'(q - zp) * longint'(scale);
      return product[SCORE_W-1:0];
   endfunction

   // Rank one score; on the last request of a vector queue its three results
   task automatic rank_score(input req_payload_type p);
      logic signed [SCORE_W-1:0] s;
      logic [11:0]               idx;
      rsp_payload_type           r;
      int                        slot;
      int                        k;
      if (class_count < MAX_CLASSES) begin
         s    = dequantize(p.raw_score);
         slot = 3;
         // slots are kept in descending order, so take the first one beaten
         for (k = 2; k >= 0; k--)
            if (s > top_score[k]) slot = k;
         if (slot < 3) begin
            for (k = 2; k > slot; k--) begin
               top_score[k] = top_score[k-1];
               top_index[k] = top_index[k-1];
               top_used[k]  = top_used[k-1];
            end
            top_score[slot] = s;
            top_index[slot] = class_count;
            top_used[slot]  = 1'b1;
         end
         class_count++;
      end
      if (p.is_last) begin
         for (k = 0; k < 3; k++) begin
            idx = top_index[k];
            r = '0;
            r.rank = 2'(k);
            r.label_kind = KIND_EMPTY;
            if (top_used[k]) begin
               if (class_count == BG_CLASS_COUNT && idx == 0) begin
                  r.label_kind = KIND_BACKGROUND;
               end else begin
                  // with a background class every label sits one lower
                  if (class_count == BG_CLASS_COUNT) idx = idx - 1'b1;
                  if (idx >= num_labels) begin
                     r.label_kind = KIND_UNKNOWN;
                  end else begin
                     r.label_kind  = KIND_LABEL;
                     r.label_index = idx[10:0];
                  end
               end
            end
            r.score = (top_score[k] < 0) ? '0 : top_score[k][32:0];
            r.last_result = (r.rank == RANK_LAST);
            pending_ranks.push_back(r);
         end
         vectors_seen++;
         clear_ranking();
      end
   endtask

   task automatic report_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
      fail_count++;
      $display("%0t: rsp %s expected %0d, got %0d", $time, field, want_v, got_v);
   endtask

   // Sample all three channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         mode_signed = 1'b1;
         zero_pt     = '0;
         scale       = 24'd65536;
         num_labels  = 12'd1000;
         clear_ranking();
         pending_ranks.delete();
         fail_count   = 0;
         vectors_seen = 0;
         results_seen = 0;
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIGNED_MODE: mode_signed = csr_data[0];
               CSR_ZERO_POINT:  zero_pt     = csr_data[8:0];
               CSR_SCALE_Q24:   scale       = csr_data;
               CSR_LABEL_COUNT: num_labels  = csr_data[11:0];
               default: ;
            endcase
         end
         // compare each result with the oldest one owed
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_ranks.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected rsp, rank %0d kind %0d score %0d", $time,
                        rsp_payload.rank, rsp_payload.label_kind, rsp_payload.score);
            end else begin
               want = pending_ranks.pop_front();
               if (rsp_payload.rank !== want.rank)
                  report_field("rank", want.rank, rsp_payload.rank);
               if (rsp_payload.label_index !== want.label_index)
                  report_field("label_index", want.label_index, rsp_payload.label_index);
               if (rsp_payload.label_kind !== want.label_kind)
                  report_field("label_kind", want.label_kind, rsp_payload.label_kind);
               if (rsp_payload.score !== want.score)
                  report_field("score", want.score, rsp_payload.score);
               if (rsp_payload.last_result !== want.last_result)
                  report_field("last_result", want.last_result, rsp_payload.last_result);
            end
         end
         if (req_valid && !req_stall) rank_score(req_payload);
      end
      pending_results = pending_ranks.size();
   end

endmodule

/* bench/dequantized_top3_selector_top_tb.sv */
// Testbench top for the dequantized top-three selector: clock, reset, request
// and register stimulus, result-side stalls and the verdict.
// Depends on dt3s_pkg, dequantized_top3_selector_top and dt3s_rank_checker.
module dequantized_top3_selector_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dt3s_pkg::*;

   localparam int MAX_CLASSES  = 2048;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SCORE_ITEMS  = 150;
   localparam int DRAIN_CYCLES = 12;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = CSR_SIGNED_MODE;
   logic [23:0]     csr_data = '0;

   // no idling on either side while set
   logic            quiet = 1'b0;

   int              cycle_count = 0;
   int              items_sent = 0;
   int              settings_loaded = 0;
   int              fail_count;
   int              pending_results;
   int              vectors_seen;
   int              results_seen;

   dequantized_top3_selector_top #(.MAX_CLASSES(MAX_CLASSES)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   dt3s_rank_checker #(.MAX_CLASSES(MAX_CLASSES)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_results(pending_results),
      .vectors_seen(vectors_seen), .results_seen(results_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock)
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 30);

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("dequantized_top3_selector_top: mismatch");
         $finish;
      end
   end

   // Offer one score request, with an optional idle gap, and hold it until taken
   task automatic send_score(input logic [7:0] raw, input logic last);
      if (!quiet && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{raw_score: raw, is_last: last};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drop valid and hold off until every owed result has come out
   task automatic wait_for_results;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write all four registers once the block is idle
   task automatic load_settings(input logic sm, input logic [8:0] zp,
                                input logic [23:0] scale, input logic [11:0] labels);
      wait_for_results();
      write_csr(CSR_SIGNED_MODE, {23'd0, sm});
      write_csr(CSR_ZERO_POINT, {15'd0, zp});
      write_csr(CSR_SCALE_Q24, scale);
      write_csr(CSR_LABEL_COUNT, {12'd0, labels});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic load_random_settings;
      logic [8:0]  zp;
      logic [23:0] scale;
      logic [11:0] labels;
      zp     = 9'($urandom_range(0, 383) - 128);
      scale  = ($urandom_range(0, 4) == 0) ? 24'hFFFFFF : 24'($urandom);
      labels = ($urandom_range(0, 4) == 0) ? 12'd2048 : 12'($urandom_range(0, 20));
      load_settings(1'($urandom_range(0, 1)), zp, scale, labels);
   endtask

   // Whole vectors of random length; repeat scores now and then to force ties
   task automatic send_random_vectors(input int count);
      int         sent;
      int         len;
      int         i;
      logic [7:0] raw;
      sent = 0;
      raw  = 8'd0;
      while (sent < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
         for (i = 1; i <= len; i++) begin
            if ($urandom_range(0, 4) != 0) raw = 8'($urandom_range(0, 255));
            send_score(raw, i == len);
         end
         sent += len;
      end
   endtask

   initial begin
      int         i;
      logic [7:0] raw;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: int8 extremes, a tie with the earlier index winning
      send_score(8'h7F, 1'b0);
      send_score(8'h80, 1'b0);
      send_score(8'h00, 1'b0);
      send_score(8'hFF, 1'b0);
      send_score(8'h7F, 1'b1);
      // one and two scores leave empty slots; a negative score clamps to zero
      send_score(8'h05, 1'b1);
      send_score(8'h80, 1'b0);
      send_score(8'h01, 1'b1);

      // Exactly -1.0 does not beat an empty slot, -0.5 does
      load_settings(1'b1, 9'd0, 24'h800000, 12'd1000);
      send_score(8'hFE, 1'b0);
      send_score(8'hFF, 1'b0);
      send_score(8'hFE, 1'b1);

      // uint8 with zero point -128 (the lowest the bench uses) and full scale: largest scores, no labels
      load_settings(1'b0, 9'h180, 24'hFFFFFF, 12'd0);
      send_score(8'hFF, 1'b0);
      send_score(8'h00, 1'b0);
      send_score(8'h80, 1'b1);

      // Highest zero point: most scores fall below -1.0
      load_settings(1'b0, 9'd255, 24'hFFFFFF, 12'd2048);
      send_score(8'h00, 1'b0);
      send_score(8'hFF, 1'b0);
      send_score(8'h7F, 1'b1);

      // Zero scale: every score ties at zero
      load_settings(1'b1, 9'd0, 24'd0, 12'd2);
      send_score(8'h11, 1'b0);
      send_score(8'h80, 1'b0);
      send_score(8'h7F, 1'b0);
      send_score(8'h22, 1'b1);

      // Long stretch without idling: a background-class vector of 1001 scores
      load_settings(1'b1, 9'd0, 24'd65536, 12'd1000);
      quiet <= 1'b1;
      for (i = 0; i < BG_CLASS_COUNT; i++) begin
         case (i)
            0:       raw = 8'd120;
            500:     raw = 8'd110;
            1000:    raw = 8'd125;
            default: raw = 8'($urandom_range(0, 100));
         endcase
         send_score(raw, i == BG_CLASS_COUNT - 1);
      end

      // Overlong vector: scores past the class limit are dropped, the last mark still emits
      load_settings(1'b0, 9'd0, 24'h100000, 12'd2048);
      for (i = 0; i < MAX_CLASSES + 2; i++) begin
         if (i >= MAX_CLASSES) raw = 8'hFF;
         else if (i == MAX_CLASSES - 1) raw = 8'd250;
         else raw = 8'($urandom_range(0, 200));
         send_score(raw, i == MAX_CLASSES + 1);
      end
      quiet <= 1'b0;

      // Random settings and vectors, pausing for all results midway in each
      for (i = 0; i < 5; i++) begin
         load_random_settings();
         send_random_vectors(SCORE_ITEMS / 10);
         wait_for_results();
         send_random_vectors(SCORE_ITEMS / 10);
      end

      wait_for_results();
      $display("Ran %0d class scores in %0d vectors across %0d register settings,",
               items_sent, vectors_seen, settings_loaded + 1);
      $display("including background, class-limit, tie and clamp cases; %0d results checked.",
               results_seen);
      if (fail_count == 0 && pending_results == 0) begin
         $display("dequantized_top3_selector_top: match");
      end else begin
         $display("dequantized_top3_selector_top: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
design/dt3s_pkg.sv
design/dequantized_top3_selector_top.sv
bench/dt3s_rank_checker.sv
bench/dequantized_top3_selector_top_tb.sv
